// ===== rtl/two_button_press_classifier_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the two-button press classifier
// Shared concurrent assertion forms, clocked on clk with async reset rst_n.
// ---------------------------------------------------------------------------
`ifndef TWO_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define TWO_BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define TBPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tbpc assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define TBPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tbpc assertion failed: next-cycle implication");

`endif

// ===== rtl/tbpc_pkg.sv =====
// ---------------------------------------------------------------------------
// tbpc_pkg
// Types, codes and reset values shared by the press classifier modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbpc_pkg;

    localparam int unsigned TICK_W = 32;
    localparam int unsigned CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT = 2'd2;

    // Reset values of the configuration registers, in ticks
    localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST = 32'd1600000;
    localparam logic [TICK_W-1:0] LONG_PRESS_TICKS_RST = 32'd80000000;
    localparam logic [TICK_W-1:0] REPEAT_TICKS_RST = 32'd8000000;

    // Button codes
    localparam logic BTN_ON = 1'b0;
    localparam logic BTN_OFF = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE     = 2'd0,
        MODE_DEBOUNCE = 2'd1,
        MODE_LONG     = 2'd2,
        MODE_REPEAT   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        EV_SHORT_PRESS  = 2'd0,
        EV_LONG_RELEASE = 2'd1,
        EV_HOLD_REPEAT  = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_press_ticks;
        logic [TICK_W-1:0] repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic        valid;
        event_kind_t kind;
        logic        button;
    } event_t;

endpackage

`default_nettype wire

// ===== rtl/two_button_press_classifier.sv =====
// ---------------------------------------------------------------------------
// two_button_press_classifier
// Debounce, long-press and hold-repeat classifier for an on and an off button.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, on_level, off_level): one beat per tick
//   carrying the sampled button levels. A beat may be taken every cycle.
//   Output channel (out_valid/out_ready, event_kind, which_button): at most
//   one event beat per input beat: short press, long press released or hold
//   repeat, tagged with the button it belongs to.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always ready;
//   index 0 debounce, 1 long press, 2 repeat period, all in ticks. Indexes
//   beyond the list are dropped. Write only while the block is quiet.
//   Output: an event is registered in the output register, or in the skid
//   register while the head stalls. Throughput: one input beat per cycle
//   while in_ready is high; the tracker updates timer and press flags per tick.
//   Stall: a two-entry output buffer (output register plus skid register)
//   keeps taking input beats while a result waits; in_ready drops only when
//   both entries hold unread events, and rises again once one is taken.
//   Reset: timers idle, button unlocked, flags clear, buffer empty, config
//   registers back to their default periods.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module two_button_press_classifier (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              on_level,
    input  wire logic                              off_level,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             event_kind,
    output logic                                   which_button,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tbpc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tbpc_pkg::TICK_W-1:0]       cfg_data
);
    import tbpc_pkg::*;

    cfg_t   cfg_reg;
    event_t ev;
    logic   tick;

    // Output register and skid register
    logic        out_valid_reg;
    event_kind_t out_kind_reg;
    logic        out_btn_reg;
    logic        skid_valid_reg;
    event_kind_t skid_kind_reg;
    logic        skid_btn_reg;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;
    assign in_ready = !skid_valid_reg;
    assign tick = in_valid && in_ready;

    // Config registers: hold until written, drop writes to unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_TICKS_RST;
            cfg_reg.long_press_ticks <= LONG_PRESS_TICKS_RST;
            cfg_reg.repeat_ticks <= REPEAT_TICKS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DEBOUNCE:   cfg_reg.debounce_ticks <= cfg_data;
                REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                REG_REPEAT:     cfg_reg.repeat_ticks <= cfg_data;
                default:        ;
            endcase
        end
    end

    tbpc_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .on_level  (on_level),
        .off_level (off_level),
        .cfg       (cfg_reg),
        .ev        (ev)
    );

    assign push = ev.valid;
    assign pop = out_valid_reg && out_ready;

    // Two-entry buffer: the output register is the head, skid the tail
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    // Advance the skid beat to the head, refill from the tracker
                    out_valid_reg <= 1'b1;
                    skid_valid_reg <= push;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                // Head is stalled: park the new beat in the skid register
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_kind_reg <= skid_kind_reg;
                out_btn_reg <= skid_btn_reg;
            end
            else if (push)
            begin
                out_kind_reg <= ev.kind;
                out_btn_reg <= ev.button;
            end
        end
        if (push)
        begin
            skid_kind_reg <= ev.kind;
            skid_btn_reg <= ev.button;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_kind = out_kind_reg;
    assign which_button = out_btn_reg;

`include "two_button_press_classifier_assert.svh"

    `TBPC_ASSERT_IMPL(a_skid_behind_head, skid_valid_reg, out_valid_reg)
    `TBPC_ASSERT_NEXT(a_stall_keeps_skid, skid_valid_reg && !out_ready, skid_valid_reg)
    `TBPC_ASSERT_NEXT(a_push_lands, push, out_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/tbpc_tracker.sv =====
// ---------------------------------------------------------------------------
// tbpc_tracker
// Press state per tick: lock, debounce, long-press and repeat timers, event.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbpc_tracker (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            tick,
    input  wire logic            on_level,
    input  wire logic            off_level,
    input  wire tbpc_pkg::cfg_t  cfg,
    output tbpc_pkg::event_t     ev
);
    import tbpc_pkg::*;

    logic [1:0]        prev_levels_reg;
    logic              locked_reg;
    logic              sel_reg;
    mode_t             mode_reg;
    logic [TICK_W-1:0] cnt_reg;
    logic              hold_reg;
    logic              rel_reg;
    logic              pend_reg;
    logic              rep_reg;

    // State after timer and edge handling, before the event is taken
    logic              locked_mid;
    logic              sel_mid;
    mode_t             mode_mid;
    logic [TICK_W-1:0] cnt_mid;
    logic              hold_mid;
    logic              rel_mid;
    logic              pend_mid;
    logic              rep_mid;

    logic              level_sel;
    logic              on_chg;
    logic              off_chg;

    logic              release_ev;
    logic              repeat_ev;

    assign level_sel = (sel_reg == BTN_OFF) ? off_level : on_level;
    assign on_chg = on_level != prev_levels_reg[0];
    assign off_chg = off_level != prev_levels_reg[1];

    // Next state: timer first, then on edge, then off edge
    always_comb
    begin
        locked_mid = locked_reg;
        sel_mid = sel_reg;
        mode_mid = mode_reg;
        cnt_mid = cnt_reg;
        hold_mid = hold_reg;
        rel_mid = rel_reg;
        pend_mid = pend_reg;
        rep_mid = rep_reg;

        if (mode_reg != MODE_IDLE)
        begin
            if (cnt_reg[TICK_W-1:1] == '0)
            begin
                cnt_mid = '0;
                unique case (mode_reg)
                    MODE_DEBOUNCE:
                    begin
                        if (level_sel)
                        begin
                            hold_mid = 1'b0;
                            rel_mid = 1'b0;
                            mode_mid = MODE_LONG;
                            cnt_mid = cfg.long_press_ticks;
                        end
                        else
                        begin
                            mode_mid = MODE_IDLE;
                            pend_mid = 1'b1;
                            rel_mid = 1'b1;
                        end
                    end
                    MODE_LONG:
                    begin
                        if (level_sel)
                        begin
                            hold_mid = 1'b1;
                            pend_mid = 1'b1;
                            mode_mid = MODE_REPEAT;
                            cnt_mid = cfg.repeat_ticks;
                        end
                        else
                        begin
                            mode_mid = MODE_IDLE;
                        end
                    end
                    MODE_REPEAT:
                    begin
                        cnt_mid = cfg.repeat_ticks;
                        rep_mid = 1'b1;
                    end
                    MODE_IDLE:
                    begin
                    end
                endcase
            end
            else
            begin
                cnt_mid = cnt_reg - TICK_W'(1);
            end
        end

        if (on_chg)
        begin
            if (!off_level && on_level && !locked_mid)
            begin
                locked_mid = 1'b1;
                sel_mid = BTN_ON;
                mode_mid = MODE_DEBOUNCE;
                cnt_mid = cfg.debounce_ticks;
            end
            else if (locked_mid && sel_mid == BTN_ON)
            begin
                mode_mid = MODE_DEBOUNCE;
                cnt_mid = cfg.debounce_ticks;
            end
        end

        if (off_chg)
        begin
            if (!on_level && off_level && !locked_mid)
            begin
                locked_mid = 1'b1;
                sel_mid = BTN_OFF;
                mode_mid = MODE_DEBOUNCE;
                cnt_mid = cfg.debounce_ticks;
            end
            else if (locked_mid && sel_mid == BTN_OFF)
            begin
                mode_mid = MODE_DEBOUNCE;
                cnt_mid = cfg.debounce_ticks;
            end
        end
    end

    // Event selection from the updated flags
    always_comb
    begin
        ev.valid = 1'b0;
        ev.kind = EV_SHORT_PRESS;
        ev.button = sel_mid;
        release_ev = 1'b0;
        repeat_ev = 1'b0;
        if (pend_mid)
        begin
            priority if (!hold_mid && rel_mid)
            begin
                release_ev = 1'b1;
                ev.kind = EV_SHORT_PRESS;
            end
            else if (hold_mid && rel_mid)
            begin
                release_ev = 1'b1;
                ev.kind = EV_LONG_RELEASE;
            end
            else if (hold_mid && !rel_mid && rep_mid)
            begin
                repeat_ev = 1'b1;
                ev.kind = EV_HOLD_REPEAT;
            end
            else
            begin
                // Hold the event back until a release or a repeat mark
                release_ev = 1'b0;
            end
        end
        ev.valid = tick && (release_ev || repeat_ev);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_levels_reg <= '0;
            locked_reg <= 1'b0;
            sel_reg <= BTN_ON;
            mode_reg <= MODE_IDLE;
            cnt_reg <= '0;
            hold_reg <= 1'b0;
            rel_reg <= 1'b0;
            pend_reg <= 1'b0;
            rep_reg <= 1'b0;
        end
        else if (tick)
        begin
            prev_levels_reg <= {off_level, on_level};
            locked_reg <= locked_mid && !release_ev;
            sel_reg <= sel_mid;
            mode_reg <= mode_mid;
            cnt_reg <= cnt_mid;
            hold_reg <= hold_mid;
            rel_reg <= rel_mid;
            pend_reg <= pend_mid && !release_ev;
            rep_reg <= rep_mid && !repeat_ev;
        end
    end

`include "two_button_press_classifier_assert.svh"

    `TBPC_ASSERT_IMPL(a_idle_count_zero, mode_reg == MODE_IDLE, cnt_reg == '0)
    `TBPC_ASSERT_IMPL(a_repeat_means_hold, mode_reg == MODE_REPEAT, hold_reg)
    `TBPC_ASSERT_NEXT(a_release_unlocks, ev.valid && release_ev, !locked_reg && !pend_reg)

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for two_button_press_classifier
// Drives button level beats through the valid/ready input channel with
// random gaps and output stalls. It tracks the debounce, long-press and
// repeat timers in its own model and compares every event beat with the
// oldest event that the model has queued. The tick periods are reprogrammed
// between phases, including zero and all-ones.
// ---------------------------------------------------------------------------

module testbench;
    import tbpc_pkg::*;

    // Index past the register list; the block drops writes to it.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        event_kind_t kind;
        logic        button;
    } press_event_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    on_level = 1'b0;
    logic                    off_level = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              event_kind;
    logic                    which_button;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = REG_DEBOUNCE;
    logic [TICK_W-1:0]       cfg_data = '0;

    // Idle odds, in percent, for each side of the block.
    int unsigned sender_idle_pct = 34;
    int unsigned receiver_idle_pct = 87;
    int unsigned levels_sent = 0;
    int unsigned mismatches = 0;

    // Events the tracker has predicted and the block has not yet delivered.
    press_event_t events_due[$];

    // Tracker copy of the tick periods and of the press state.
    logic [TICK_W-1:0] cfg_debounce = DEBOUNCE_TICKS_RST;
    logic [TICK_W-1:0] cfg_long = LONG_PRESS_TICKS_RST;
    logic [TICK_W-1:0] cfg_repeat = REPEAT_TICKS_RST;
    logic [1:0]        trk_prev_levels = 2'b00;   // bit 0 on, bit 1 off
    logic              trk_locked = 1'b0;
    logic              trk_button = BTN_ON;
    mode_t             trk_mode = MODE_IDLE;
    logic [TICK_W-1:0] trk_count = '0;
    logic              trk_hold = 1'b0;
    logic              trk_released = 1'b0;
    logic              trk_pending = 1'b0;
    logic              trk_rep_due = 1'b0;

    two_button_press_classifier dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .on_level     (on_level),
        .off_level    (off_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_kind   (event_kind),
        .which_button (which_button),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Stall the event channel at random; the odds change between phases.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // ------------------------------------------------------------------
    // Press tracker
    // ------------------------------------------------------------------

    // Lock onto a button that rises alone, or restart the debounce when the
    // locked button moves. Changes on the other button fall through.
    function automatic void handle_button_edge(input logic btn, input logic mine,
                                               input logic other);
        if (!other && mine && !trk_locked)
        begin
            trk_locked = 1'b1;
            trk_button = btn;
            trk_mode   = MODE_DEBOUNCE;
            trk_count  = cfg_debounce;
        end
        else if (trk_locked && trk_button == btn)
        begin
            trk_mode  = MODE_DEBOUNCE;
            trk_count = cfg_debounce;
        end
    endfunction

    // Advance the tracker by one tick and queue the event it reports, if any.
    function automatic void advance_press_tracker(input logic on_lv, input logic off_lv);
        logic         pressed;
        press_event_t ev;
        pressed = (trk_button == BTN_OFF) ? off_lv : on_lv;

        // Count down first; a period of zero or one expires on this tick.
        if (trk_mode != MODE_IDLE)
        begin
            if (trk_count > 32'd1)
            begin
                trk_count = trk_count - 32'd1;
            end
            else
            begin
                trk_count = '0;
                case (trk_mode)
                    MODE_DEBOUNCE:
                    begin
                        if (pressed)
                        begin
                            trk_hold     = 1'b0;
                            trk_released = 1'b0;
                            trk_mode     = MODE_LONG;
                            trk_count    = cfg_long;
                        end
                        else
                        begin
                            trk_mode     = MODE_IDLE;
                            trk_pending  = 1'b1;
                            trk_released = 1'b1;
                        end
                    end
                    MODE_LONG:
                    begin
                        if (pressed)
                        begin
                            trk_hold    = 1'b1;
                            trk_pending = 1'b1;
                            trk_mode    = MODE_REPEAT;
                            trk_count   = cfg_repeat;
                        end
                        else
                        begin
                            trk_mode = MODE_IDLE;
                        end
                    end
                    MODE_REPEAT:
                    begin
                        trk_count   = cfg_repeat;
                        trk_rep_due = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // On button first, as in the block; locking needs the other one low.
        if (on_lv != trk_prev_levels[0])
            handle_button_edge(BTN_ON, on_lv, off_lv);
        if (off_lv != trk_prev_levels[1])
            handle_button_edge(BTN_OFF, off_lv, on_lv);

        // A release ends the press and unlocks; a due repeat mark is left
        // alone on release and may surface on the next hold.
        ev.button = trk_button;
        if (trk_pending)
        begin
            if (trk_released)
            begin
                trk_pending = 1'b0;
                trk_locked  = 1'b0;
                ev.kind     = trk_hold ? EV_LONG_RELEASE : EV_SHORT_PRESS;
                events_due.push_back(ev);
            end
            else if (trk_hold && trk_rep_due)
            begin
                trk_rep_due = 1'b0;
                ev.kind     = EV_HOLD_REPEAT;
                events_due.push_back(ev);
            end
        end

        trk_prev_levels = {off_lv, on_lv};
    endfunction

    // ------------------------------------------------------------------
    // Event checker: compare each delivered beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_events
        press_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, got kind %0d button %0d",
                         $time, event_kind, which_button);
                mismatches++;
            end
            else
            begin
                want = events_due.pop_front();
                if (event_kind !== want.kind)
                begin
                    $display("%0t: event_kind expected %0d, got %0d",
                             $time, want.kind, event_kind);
                    mismatches++;
                end
                if (which_button !== want.button)
                begin
                    $display("%0t: which_button expected %0d, got %0d",
                             $time, want.button, which_button);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared drivers; each one starts and ends at a falling edge
    // ------------------------------------------------------------------

    // Send one level beat; hold valid and payload until the block takes it.
    task automatic send_levels(input logic on_lv, input logic off_lv);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        on_level  <= on_lv;
        off_level <= off_lv;
        do
            @(posedge clk);
        while (!in_ready);
        advance_press_tracker(on_lv, off_lv);
        levels_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted event has arrived, then
    // let the inputs idle over further falling edges before returning.
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (events_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register while the block is quiet.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [TICK_W-1:0] value);
        wait_until_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEBOUNCE:   cfg_debounce = value;
            REG_LONG_PRESS: cfg_long = value;
            REG_REPEAT:     cfg_repeat = value;
            default:
            begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_periods(input logic [TICK_W-1:0] debounce,
                                 input logic [TICK_W-1:0] long_press,
                                 input logic [TICK_W-1:0] period);
        write_register(REG_DEBOUNCE, debounce);
        write_register(REG_LONG_PRESS, long_press);
        write_register(REG_REPEAT, period);
    endtask

    // One press: optional bounces, a steady hold, then both buttons low.
    task automatic press_button(input logic btn, input int unsigned hold_ticks,
                                input int unsigned release_ticks,
                                input int unsigned bounces);
        logic lv_on;
        logic lv_off;
        lv_on  = (btn == BTN_ON);
        lv_off = (btn == BTN_OFF);
        repeat (bounces)
        begin
            send_levels(lv_on, lv_off);
            send_levels(1'b0, 1'b0);
        end
        repeat (hold_ticks) send_levels(lv_on, lv_off);
        repeat (release_ticks) send_levels(1'b0, 1'b0);
    endtask

    // Mostly short periods; zero and all-ones turn up now and then.
    function automatic logic [TICK_W-1:0] pick_ticks();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3)
            return '1;
        if (roll < 8)
            return '0;
        return $urandom_range(1, 4);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default periods are far too long to end within a few ticks: no events.
    task automatic test_reset_values();
        send_levels(1'b1, 1'b0);
        send_levels(1'b0, 1'b0);
    endtask

    // Debounce ending low before any long press reports a short press.
    task automatic test_short_press();
        write_periods(32'd2, 32'd3, 32'd2);
        press_button(BTN_ON, 1, 4, 0);
    endtask

    // Hold past the long period for repeats, then release for a long release.
    task automatic test_long_press();
        write_periods(32'd2, 32'd2, 32'd1);
        press_button(BTN_OFF, 7, 3, 0);
    endtask

    // Both buttons at once, a joint change that locks the on button, and
    // changes on the other button while locked.
    task automatic test_joint_changes();
        send_levels(1'b1, 1'b1);
        send_levels(1'b0, 1'b1);
        send_levels(1'b1, 1'b0);
        send_levels(1'b1, 1'b1);
        send_levels(1'b0, 1'b0);
        send_levels(1'b0, 1'b0);
        send_levels(1'b0, 1'b0);
    endtask

    // A period of zero behaves like one.
    task automatic test_zero_periods();
        write_periods('0, '0, '0);
        press_button(BTN_OFF, 1, 2, 0);
        press_button(BTN_ON, 3, 2, 0);
    endtask

    // All-ones periods never run out here; a write past the list is dropped.
    task automatic test_extreme_periods();
        write_periods('1, '1, '1);
        send_levels(1'b1, 1'b0);
        send_levels(1'b0, 1'b0);
        write_register(REG_UNUSED, $urandom);
    endtask

    // Random traffic: mostly whole presses with random timing, the rest
    // noise; reprogram the periods every few dozen beats.
    task automatic test_random_presses(input int unsigned item_count);
        int unsigned stop_at;
        int unsigned block_end;
        int unsigned span;
        int unsigned tail;
        int unsigned bounces;
        logic        btn;
        stop_at   = levels_sent + item_count;
        block_end = levels_sent;
        while (levels_sent < stop_at)
        begin
            if (levels_sent >= block_end)
            begin
                write_periods(pick_ticks(), pick_ticks(), pick_ticks());
                block_end = levels_sent + $urandom_range(30, 70);
            end
            // Reach a few repeats when the periods are short; cap otherwise.
            if (cfg_debounce > 8 || cfg_long > 8 || cfg_repeat > 8)
            begin
                span = 12;
                tail = 4;
            end
            else
            begin
                span = cfg_debounce + cfg_long + 3 * cfg_repeat + 4;
                tail = cfg_debounce + 3;
            end
            if ($urandom_range(99) < 80)
            begin
                btn     = ($urandom_range(1) != 0) ? BTN_OFF : BTN_ON;
                bounces = ($urandom_range(99) < 25) ? $urandom_range(1, 3) : 0;
                press_button(btn, $urandom_range(1, span), $urandom_range(1, tail),
                             bounces);
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_levels($urandom_range(1) != 0, $urandom_range(1) != 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_values();
        test_short_press();
        test_long_press();
        test_joint_changes();
        test_zero_periods();
        test_extreme_periods();

        test_random_presses(250);
        sender_idle_pct   = 87;
        receiver_idle_pct = 34;
        test_random_presses(250);
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        test_random_presses(250);

        wait_until_quiet();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run; far beyond the slowest correct one.
    initial
    begin
        #400_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
